>>> rtl/core/pnrf_pkg.sv
// ----------------------------------------------------------------------------
// pnrf_pkg: shared types and arithmetic for the polynomial root finder
// Codes, state encoding and Q16.16 saturating helpers.
// ----------------------------------------------------------------------------
package pnrf_pkg;

	localparam int MAX_DEGREE_DEF = 15;
	localparam int S_TDATA_W      = 72;
	localparam int M_TDATA_W      = 32;
	localparam int DIV_STEPS      = 48;

	typedef enum logic [1:0] {
		ACT_ADD   = 2'd0,
		ACT_SOLVE = 2'd1,
		ACT_CLEAR = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_FOUND      = 2'd0,
		ST_NO_POLY    = 2'd1,
		ST_NO_CONV    = 2'd2,
		ST_ZERO_DERIV = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_MAX_ITER  = 2'd0,
		REG_STEP_TOL  = 2'd1,
		REG_VALUE_THR = 2'd2
	} reg_idx_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_ADD_RD,
		S_ADD_WR,
		S_SCAN,
		S_LIN_RD1,
		S_LIN_RD0,
		S_LIN_GO,
		S_E_RDTOP,
		S_E_TOP,
		S_E_TOP2,
		S_E_RD,
		S_E_MF,
		S_E_MD,
		S_E_MK,
		S_E_AD,
		S_E_DONE,
		S_DIV,
		S_DIV_DONE,
		S_DONE
	} state_t;

	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	// clamp a 64-bit value to the signed 32-bit range
	function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = Q_MAX;
		end else if (v < -64'sd2147483648) begin
			r = Q_MIN;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Q16.16 product scaling: round half up, then clamp
	function automatic logic signed [31:0] rnd_sat(input logic signed [63:0] p);
		logic signed [63:0] r;
		r = (p + 64'sd32768) >>> 16;
		return sat64(r);
	endfunction

	// saturating add / subtract
	function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
	                                               input logic signed [31:0] b);
		logic signed [32:0] s;
		logic signed [31:0] r;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31]) begin
			r = s[32] ? Q_MIN : Q_MAX;
		end else begin
			r = s[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
	                                               input logic signed [31:0] b);
		logic signed [32:0] s;
		logic signed [31:0] r;
		s = {a[31], a} - {b[31], b};
		if (s[32] != s[31]) begin
			r = s[32] ? Q_MIN : Q_MAX;
		end else begin
			r = s[31:0];
		end
		return r;
	endfunction

	// magnitude of a signed word, exact for the most negative value
	function automatic logic [31:0] abs32(input logic signed [31:0] a);
		return a[31] ? (~a + 32'd1) : a;
	endfunction

endpackage

>>> rtl/core/poly_newton_root_finder.sv
// ----------------------------------------------------------------------------
// poly_newton_root_finder: Newton root search on a Q16.16 polynomial
// Coefficient store, Horner evaluation on one shared multiplier and a
// one-bit-per-cycle divider under a small sequencer.
// ----------------------------------------------------------------------------
// Add-term transactions read the slot (S_ADD_RD), then write the sum
// (S_ADD_WR); a clear is taken in idle and resets the nonzero bits.
// A solve first scans the store from the top power down, one slot a
// cycle. Degree 1 is one divide. Otherwise each evaluation of f and f'
// at an iterate runs Horner's scheme on the single 32x32 multiplier,
// and each Newton step adds a divide, for up to max_iterations
// iterations. One item is in work at a time; the result waits in an output
// register, and add/clear transactions are taken while it waits. The store
// needs no clearing pass: a per-slot nonzero bit, cleared by reset and by the
// clear action, masks stale memory contents.
module poly_newton_root_finder
	import pnrf_pkg::*;
#(
	parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// slave stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // term_power[3:0], term_coeff[35:4],
	                                       // start_guess[67:36], zero pad
	input  logic [1:0]           s_tuser,  // action[1:0]
	// master stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // root[31:0]
	output logic [1:0]           m_tuser,  // status[1:0]
	// configuration
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int SLOTS = MAX_DEGREE + 1;
	localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW    = $clog2(DIV_STEPS);

	state_t state_q, state_d;

	// configuration registers
	logic [9:0]  max_iter_q;
	logic [30:0] step_tol_q;
	logic [30:0] value_thr_q;

	// coefficient store and nonzero marks
	logic signed [31:0] mem [SLOTS];
	logic signed [31:0] rdata_q;
	logic               rd_nz_q;
	logic [SLOTS-1:0]   nz_q;
	logic [AW-1:0]      raddr;
	logic signed [31:0] eff;

	// captured transaction
	logic [3:0]         pw_q;
	logic signed [31:0] tc_q;
	logic               in_range_q;

	// solver datapath
	logic signed [31:0] x_q, facc_q, dacc_q, coef_q, t_q, den_q;
	logic [AW-1:0]      k_q, deg_q;
	logic [9:0]         iter_q;
	logic               first_q, lin_q;
	logic signed [63:0] prod_q;
	logic signed [31:0] mul_a, mul_b;

	// divider
	logic [47:0]        dvd_q;
	logic [31:0]        rem_q, dsr_q;
	logic [CW-1:0]      cnt_q;
	logic               neg_q;
	logic [32:0]        trial;
	logic               qbit;

	// result
	logic signed [31:0] res_root_q;
	status_t            res_st_q;
	logic               m_tvalid_q;
	logic [31:0]        m_root_q;
	logic [1:0]         m_st_q;

	// combinational helpers
	logic               s_acc, cfg_wr;
	logic signed [31:0] add_sum, qsat, next_x;
	logic signed [32:0] step_d;
	logic [32:0]        step_mag;
	logic               lin_num_neg;

	assign s_acc    = s_tvalid && s_tready;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign pready   = 1'b1;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_root_q;
	assign m_tuser  = m_st_q;

	assign eff = rd_nz_q ? rdata_q : 32'sd0;

	// register read back
	always_comb begin
		unique case (paddr[3:2])
			REG_MAX_ITER:  prdata = {22'd0, max_iter_q};
			REG_STEP_TOL:  prdata = {1'b0, step_tol_q};
			REG_VALUE_THR: prdata = {1'b0, value_thr_q};
			default:       prdata = 32'd0;
		endcase
	end

	// store read address
	always_comb begin
		unique case (state_q)
			S_ADD_RD:  raddr = AW'(pw_q);
			S_E_RDTOP: raddr = deg_q;
			S_LIN_RD1: raddr = AW'(1);
			S_LIN_RD0: raddr = AW'(0);
			default:   raddr = k_q;
		endcase
	end

	// shared multiplier operand select
	always_comb begin
		unique case (state_q)
			S_E_TOP: begin
				mul_a = eff;
				mul_b = $signed(32'(deg_q));
			end
			S_E_MF: begin
				mul_a = facc_q;
				mul_b = x_q;
			end
			S_E_MD: begin
				mul_a = dacc_q;
				mul_b = x_q;
			end
			S_E_MK: begin
				mul_a = coef_q;
				mul_b = $signed(32'(k_q));
			end
			default: begin
				mul_a = 32'sd0;
				mul_b = 32'sd0;
			end
		endcase
	end

	// divider step, quotient clamp and Newton update
	always_comb begin
		trial = {rem_q, dvd_q[47]};
		qbit  = (trial >= {1'b0, dsr_q});
		if (neg_q) begin
			qsat = (dvd_q > 48'h0000_8000_0000) ? Q_MIN : $signed(32'(~dvd_q + 48'd1));
		end else begin
			qsat = (dvd_q > 48'h0000_7FFF_FFFF) ? Q_MAX : $signed(dvd_q[31:0]);
		end
		next_x      = sub_sat(x_q, qsat);
		step_d      = {next_x[31], next_x} - {x_q[31], x_q};
		step_mag    = step_d[32] ? 33'(-step_d) : 33'(step_d);
		add_sum     = add_sat(eff, tc_q);
		lin_num_neg = !eff[31] && (eff != 32'sd0);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_acc) begin
					case (s_tuser)
						ACT_ADD:   state_d = S_ADD_RD;
						ACT_SOLVE: state_d = S_SCAN;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_ADD_RD: state_d = S_ADD_WR;
			S_ADD_WR: state_d = S_IDLE;
			S_SCAN: begin
				if (nz_q[k_q]) begin
					if (k_q == AW'(0)) begin
						state_d = S_DONE;
					end else if (k_q == AW'(1)) begin
						state_d = S_LIN_RD1;
					end else begin
						state_d = S_E_RDTOP;
					end
				end else if (k_q == AW'(0)) begin
					state_d = S_DONE;
				end
			end
			S_LIN_RD1: state_d = S_LIN_RD0;
			S_LIN_RD0: state_d = S_LIN_GO;
			S_LIN_GO:  state_d = S_DIV;
			S_E_RDTOP: state_d = S_E_TOP;
			S_E_TOP:   state_d = S_E_TOP2;
			S_E_TOP2:  state_d = S_E_RD;
			S_E_RD:    state_d = S_E_MF;
			S_E_MF:    state_d = S_E_MD;
			S_E_MD:    state_d = (k_q == AW'(0)) ? S_E_DONE : S_E_MK;
			S_E_MK:    state_d = S_E_AD;
			S_E_AD:    state_d = S_E_RD;
			S_E_DONE: begin
				if (first_q && ({1'b0, abs32(facc_q)} < {2'b0, value_thr_q})) begin
					state_d = S_DONE;
				end else if (iter_q == max_iter_q || dacc_q == 32'sd0) begin
					state_d = S_DONE;
				end else begin
					state_d = S_DIV;
				end
			end
			S_DIV:      state_d = (cnt_q == CW'(DIV_STEPS - 1)) ? S_DIV_DONE : S_DIV;
			S_DIV_DONE: begin
				if (lin_q || step_mag < {2'b0, step_tol_q}) begin
					state_d = S_DONE;
				end else begin
					state_d = S_E_RDTOP;
				end
			end
			S_DONE: state_d = (!m_tvalid_q || m_tready) ? S_IDLE : S_DONE;
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			max_iter_q  <= 10'd100;
			step_tol_q  <= 31'd66;
			value_thr_q <= 31'd66;
			nz_q        <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				case (paddr[3:2])
					REG_MAX_ITER:  max_iter_q  <= pwdata[9:0];
					REG_STEP_TOL:  step_tol_q  <= pwdata[30:0];
					REG_VALUE_THR: value_thr_q <= pwdata[30:0];
					default: ;
				endcase
			end
			if (s_acc && s_tuser == ACT_CLEAR) begin
				nz_q <= '0;
			end
			if (state_q == S_ADD_WR && in_range_q) begin
				nz_q[AW'(pw_q)] <= (add_sum != 32'sd0);
			end
			if (state_q == S_DONE && !m_tvalid_q) begin
				m_tvalid_q <= 1'b1;
			end else if (state_q == S_DONE && m_tready) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// coefficient memory
	always_ff @(posedge clk) begin
		if (state_q == S_ADD_WR && in_range_q) begin
			mem[AW'(pw_q)] <= add_sum;
		end
		rdata_q <= mem[raddr];
		rd_nz_q <= nz_q[raddr];
	end

	// solver datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			S_IDLE: begin
				pw_q       <= s_tdata[3:0];
				tc_q       <= $signed(s_tdata[35:4]);
				x_q        <= $signed(s_tdata[67:36]);
				in_range_q <= (32'(s_tdata[3:0]) <= 32'(MAX_DEGREE));
				k_q        <= AW'(MAX_DEGREE);
			end
			S_SCAN: begin
				if (nz_q[k_q] && k_q != AW'(0)) begin
					deg_q   <= k_q;
					first_q <= 1'b1;
					iter_q  <= 10'd0;
					lin_q   <= (k_q == AW'(1));
				end else if (k_q == AW'(0)) begin
					res_root_q <= 32'sd0;
					res_st_q   <= ST_NO_POLY;
				end else begin
					k_q <= k_q - AW'(1);
				end
			end
			S_LIN_RD0: den_q <= eff;
			S_LIN_GO: begin
				dvd_q <= {abs32(eff), 16'd0};
				dsr_q <= abs32(den_q);
				neg_q <= lin_num_neg ^ den_q[31];
				rem_q <= 32'd0;
				cnt_q <= '0;
			end
			S_E_TOP: facc_q <= eff;
			S_E_TOP2: begin
				dacc_q <= sat64(prod_q);
				k_q    <= deg_q - AW'(1);
			end
			S_E_MF: coef_q <= eff;
			S_E_MD: facc_q <= add_sat(rnd_sat(prod_q), coef_q);
			S_E_MK: t_q <= rnd_sat(prod_q);
			S_E_AD: begin
				dacc_q <= add_sat(t_q, sat64(prod_q));
				k_q    <= k_q - AW'(1);
			end
			S_E_DONE: begin
				first_q <= 1'b0;
				if (first_q && ({1'b0, abs32(facc_q)} < {2'b0, value_thr_q})) begin
					res_root_q <= x_q;
					res_st_q   <= ST_FOUND;
				end else if (iter_q == max_iter_q) begin
					res_root_q <= 32'sd0;
					res_st_q   <= ST_NO_CONV;
				end else if (dacc_q == 32'sd0) begin
					res_root_q <= 32'sd0;
					res_st_q   <= ST_ZERO_DERIV;
				end else begin
					dvd_q <= {abs32(facc_q), 16'd0};
					dsr_q <= abs32(dacc_q);
					neg_q <= facc_q[31] ^ dacc_q[31];
					rem_q <= 32'd0;
					cnt_q <= '0;
				end
			end
			S_DIV: begin
				rem_q <= qbit ? 32'(trial - {1'b0, dsr_q}) : trial[31:0];
				dvd_q <= {dvd_q[46:0], qbit};
				cnt_q <= cnt_q + CW'(1);
			end
			S_DIV_DONE: begin
				if (lin_q) begin
					res_root_q <= qsat;
					res_st_q   <= ST_FOUND;
				end else if (step_mag < {2'b0, step_tol_q}) begin
					res_root_q <= next_x;
					res_st_q   <= ST_FOUND;
				end else begin
					x_q    <= next_x;
					iter_q <= iter_q + 10'd1;
				end
			end
			S_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					m_root_q <= res_root_q;
					m_st_q   <= res_st_q;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	// a result appears only out of the completion state
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == S_DONE)
		else $error("result raised outside completion state");

	// every failure status carries a zero root
	a_fail_root_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_FOUND) |-> m_tdata == 32'd0)
		else $error("nonzero root with failure status");

	// a clear transaction empties the store
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == ACT_CLEAR) |=> nz_q == '0)
		else $error("store not empty after clear");
`endif

endmodule
